@@ rtl/ltfs_pkg.sv @@
package ltfs_pkg;

   localparam int MaxDim = 16;
   localparam int IdxW = 4;
   localparam int SizeW = 5;
   localparam int QueueDepth = 4;
   localparam int QueuePtrW = 2;

   localparam logic OP_FACTOR = 1'b0;
   localparam logic OP_VECTOR = 1'b1;

   typedef struct packed {
      logic               operation;
      logic [IdxW-1:0]    row;
      logic [IdxW-1:0]    column;
      logic signed [31:0] value;
      logic               last_element;
   } req_type;

   typedef struct packed {
      logic signed [31:0] solution_value;
      logic [IdxW-1:0]    element_index;
      logic               last_result;
      logic               divide_error;
   } rsp_type;

   typedef struct packed {
      logic               is_factor;
      logic [IdxW-1:0]    row;
      logic [IdxW-1:0]    column;
      logic signed [31:0] value;
      logic               start;
   } cmd_type;

   typedef enum logic [2:0] {
      ST_IDLE,
      ST_MAC_RD,
      ST_MAC,
      ST_DIV_SETUP,
      ST_DIV,
      ST_EMIT
   } solve_state_type;

endpackage

@@ rtl/ltfs_front.sv @@
module ltfs_front (
   input  logic              clock,
   input  logic              reset,
   input  logic              req_valid,
   output logic              req_stall,
   input  ltfs_pkg::req_type req_payload,
   output logic              cmd_valid,
   input  logic              cmd_stall,
   output ltfs_pkg::cmd_type cmd_payload
);
   import ltfs_pkg::*;

   cmd_type                 queue_ff [QueueDepth];
   logic [QueuePtrW-1:0]    wr_ptr_ff, wr_ptr_in, rd_ptr_ff, rd_ptr_in;
   logic [QueuePtrW:0]      count_ff, count_in;
   logic                    push, pop;
   cmd_type                 cmd_new;

   always_comb begin
      cmd_new.is_factor = (req_payload.operation == OP_FACTOR);
      cmd_new.row       = req_payload.row;
      cmd_new.column    = req_payload.column;
      cmd_new.value     = req_payload.value;
      cmd_new.start     = (req_payload.operation == OP_VECTOR) && req_payload.last_element;
   end

   assign req_stall   = (count_ff == (QueuePtrW+1)'(QueueDepth));
   assign push        = req_valid && !req_stall;
   assign cmd_valid   = (count_ff != '0);
   assign pop         = cmd_valid && !cmd_stall;
   assign cmd_payload = queue_ff[rd_ptr_ff];

   always_comb begin
      wr_ptr_in = push ? wr_ptr_ff + 1'b1 : wr_ptr_ff;
      rd_ptr_in = pop ? rd_ptr_ff + 1'b1 : rd_ptr_ff;
      count_in  = count_ff + (QueuePtrW+1)'(push) - (QueuePtrW+1)'(pop);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (push) begin
         queue_ff[wr_ptr_ff] <= cmd_new;
      end
   end

   queue_bound: assert property (@(posedge clock) disable iff (reset)
      count_ff <= (QueuePtrW+1)'(QueueDepth))
      else $error("queue count overflow");
   empty_no_pop: assert property (@(posedge clock) disable iff (reset)
      (count_ff == '0) |-> !pop)
      else $error("pop from empty queue");
   full_no_push: assert property (@(posedge clock) disable iff (reset)
      (count_ff == (QueuePtrW+1)'(QueueDepth)) |-> !push)
      else $error("push into full queue");

endmodule

@@ rtl/ltfs_divider.sv @@
module ltfs_divider (
   input  logic               clock,
   input  logic               reset,
   input  logic               start,
   input  logic signed [47:0] numerator,
   input  logic signed [31:0] divisor,
   output logic               done,
   output logic signed [31:0] quotient
);
   import ltfs_pkg::*;

   // restoring divide of |num|*2^16 (63 bits) by |d|, one bit per cycle
   logic [62:0] dividend_ff, dividend_in;
   logic [31:0] rem_ff, rem_in;
   logic [31:0] den_ff, den_in;
   logic [5:0]  cnt_ff, cnt_in;
   logic        busy_ff, busy_in;
   logic        neg_ff, neg_in;
   logic        done_ff, done_in;
   logic [62:0] num_abs;
   logic [33:0] trial;
   logic [32:0] rem_shift;
   logic [63:0] q_signed;

   always_comb begin
      num_abs     = numerator[47] ? 63'(-{{15{numerator[47]}}, numerator}) << 16
                                  : 63'({15'd0, numerator}) << 16;
      rem_shift   = {rem_ff, dividend_ff[62]};
      trial       = {1'b0, rem_shift} - {2'b00, den_ff};
      dividend_in = dividend_ff;
      rem_in      = rem_ff;
      den_in      = den_ff;
      cnt_in      = cnt_ff;
      busy_in     = busy_ff;
      neg_in      = neg_ff;
      done_in     = 1'b0;
      if (start) begin
         dividend_in = num_abs;
         rem_in      = '0;
         den_in      = divisor[31] ? 32'(-divisor) : divisor;
         cnt_in      = 6'd62;
         busy_in     = 1'b1;
         neg_in      = numerator[47] ^ divisor[31];
      end else if (busy_ff) begin
         if (!trial[33]) begin
            rem_in = trial[31:0];
         end else begin
            rem_in = rem_shift[31:0];
         end
         dividend_in = {dividend_ff[61:0], ~trial[33]};
         if (cnt_ff == '0) begin
            busy_in = 1'b0;
            done_in = 1'b1;
         end else begin
            cnt_in = cnt_ff - 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
      end else begin
         busy_ff <= busy_in;
         done_ff <= done_in;
      end
   end

   always_ff @(posedge clock) begin
      dividend_ff <= dividend_in;
      rem_ff      <= rem_in;
      den_ff      <= den_in;
      cnt_ff      <= cnt_in;
      neg_ff      <= neg_in;
   end

   // quotient magnitude < 2^63; saturate to 32 bits
   always_comb begin
      q_signed = neg_ff ? -{1'b0, dividend_ff} : {1'b0, dividend_ff};
      if (!neg_ff && dividend_ff > 63'h7FFF_FFFF) begin
         quotient = 32'sh7FFF_FFFF;
      end else if (neg_ff && dividend_ff > 63'h8000_0000) begin
         quotient = 32'sh8000_0000;
      end else begin
         quotient = q_signed[31:0];
      end
   end

   assign done = done_ff;

   done_one_cycle: assert property (@(posedge clock) disable iff (reset)
      done_ff |=> !done_ff)
      else $error("done held");
   done_after_busy: assert property (@(posedge clock) disable iff (reset)
      done_ff |-> $past(busy_ff))
      else $error("done without busy");
   no_start_busy: assert property (@(posedge clock) disable iff (reset)
      busy_ff |-> !start)
      else $error("start while busy");

endmodule

@@ rtl/ltfs_back.sv @@
module ltfs_back (
   input  logic                          clock,
   input  logic                          reset,
   input  logic [ltfs_pkg::SizeW-1:0]    dim,
   input  logic                          cmd_valid,
   output logic                          cmd_stall,
   input  ltfs_pkg::cmd_type             cmd_payload,
   output logic                          rsp_valid,
   input  logic                          rsp_stall,
   output ltfs_pkg::rsp_type             rsp_payload
);
   import ltfs_pkg::*;

   logic signed [31:0] factor_mem [MaxDim*MaxDim];
   logic signed [31:0] vector_mem [MaxDim];

   solve_state_type state_ff, state_in;
   logic [IdxW-1:0]    i_ff, i_in, j_ff, j_in;
   logic signed [63:0] acc_ff, acc_in;
   logic signed [31:0] fac_rd_ff, vec_rd_ff, bi_ff;
   logic signed [63:0] prod_ff;
   logic               rd_vld_ff;
   logic               prod_vld_ff;
   logic               diag_rd_ff;
   logic signed [31:0] diag_ff;
   rsp_type            out_ff, out_in;
   logic               out_vld_ff, out_vld_in;
   logic [7:0]         fac_addr;
   logic [IdxW-1:0]    vec_addr;
   logic               cmd_take, wr_back, div_start, div_done;
   logic signed [31:0] div_q, y_val;
   logic signed [63:0] num_full;
   logic signed [47:0] num_clamp;
   logic               last_i;
   logic               mac_issue;

   assign last_i    = ({1'b0, i_ff} == dim - 1'b1);
   assign cmd_stall = (state_ff != ST_IDLE);
   assign cmd_take  = cmd_valid && !cmd_stall;

   // next state
   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         ST_IDLE: begin
            if (cmd_take && cmd_payload.start) begin
               state_in = ST_MAC_RD;
            end
         end
         ST_MAC_RD: state_in = ST_MAC;
         ST_MAC: begin
            if (j_ff == i_ff && !rd_vld_ff && !prod_vld_ff) begin
               state_in = ST_DIV_SETUP;
            end
         end
         ST_DIV_SETUP: state_in = ST_DIV;
         ST_DIV: begin
            if (div_done || diag_ff == '0) begin
               state_in = ST_EMIT;
            end
         end
         ST_EMIT: begin
            if (!out_vld_ff || !rsp_stall) begin
               state_in = last_i ? ST_IDLE : ST_MAC_RD;
            end
         end
         default: state_in = ST_IDLE;
      endcase
   end

   // datapath control
   always_comb begin
      i_in       = i_ff;
      j_in       = j_ff;
      acc_in     = acc_ff;
      mac_issue  = 1'b0;
      div_start  = 1'b0;
      wr_back    = 1'b0;
      fac_addr   = {i_ff, i_ff};
      vec_addr   = i_ff;
      out_in     = out_ff;
      out_vld_in = out_vld_ff && rsp_stall;
      num_full   = {{32{bi_ff[31]}}, bi_ff} - acc_ff;
      if (num_full > 64'sd70368744177664) begin
         num_clamp = 48'sh4000_0000_0000;
      end else if (num_full < -64'sd70368744177664) begin
         num_clamp = -48'sh4000_0000_0000;
      end else begin
         num_clamp = num_full[47:0];
      end
      y_val = (diag_ff == '0) ? 32'sd0 : div_q;
      unique case (state_ff)
         ST_IDLE: begin
            i_in   = '0;
            j_in   = '0;
            acc_in = '0;
         end
         ST_MAC_RD: begin
            j_in = '0;
            acc_in = '0;
         end
         ST_MAC: begin
            if (j_ff != i_ff) begin
               fac_addr  = {j_ff, i_ff};
               vec_addr  = j_ff;
               mac_issue = 1'b1;
               j_in      = j_ff + 1'b1;
            end
            if (prod_vld_ff) begin
               acc_in = acc_ff + (prod_ff >>> 16);
            end
         end
         ST_DIV_SETUP: begin
            div_start = (diag_ff != '0);
         end
         ST_DIV: ;
         ST_EMIT: begin
            if (!out_vld_ff || !rsp_stall) begin
               out_in.solution_value = y_val;
               out_in.element_index  = i_ff;
               out_in.last_result    = last_i;
               out_in.divide_error   = (diag_ff == '0);
               out_vld_in            = 1'b1;
               wr_back               = 1'b1;
               i_in                  = i_ff + 1'b1;
            end
         end
         default: ;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff    <= ST_IDLE;
         out_vld_ff  <= 1'b0;
         rd_vld_ff   <= 1'b0;
         prod_vld_ff <= 1'b0;
         diag_rd_ff  <= 1'b0;
      end else begin
         state_ff    <= state_in;
         out_vld_ff  <= out_vld_in;
         rd_vld_ff   <= mac_issue;
         prod_vld_ff <= rd_vld_ff;
         diag_rd_ff  <= (state_ff == ST_MAC_RD);
      end
   end

   always_ff @(posedge clock) begin
      i_ff   <= i_in;
      j_ff   <= j_in;
      acc_ff <= acc_in;
      out_ff <= out_in;
      prod_ff <= 64'(fac_rd_ff) * 64'(vec_rd_ff);
      if (diag_rd_ff) begin
         bi_ff   <= vec_rd_ff;
         diag_ff <= fac_rd_ff;
      end
   end

   // memories: registered reads, writes from commands and write-back
   always_ff @(posedge clock) begin
      fac_rd_ff <= factor_mem[fac_addr];
      vec_rd_ff <= vector_mem[vec_addr];
      if (cmd_take && cmd_payload.is_factor) begin
         factor_mem[{cmd_payload.row, cmd_payload.column}] <= cmd_payload.value;
      end
      if (cmd_take && !cmd_payload.is_factor) begin
         vector_mem[cmd_payload.row] <= cmd_payload.value;
      end else if (wr_back) begin
         vector_mem[i_ff] <= y_val;
      end
   end

   ltfs_divider u_div (
      .clock     (clock),
      .reset     (reset),
      .start     (div_start),
      .numerator (num_clamp),
      .divisor   (diag_ff),
      .done      (div_done),
      .quotient  (div_q)
   );

   assign rsp_valid   = out_vld_ff;
   assign rsp_payload = out_ff;

   idle_accepts: assert property (@(posedge clock) disable iff (reset)
      (state_ff != ST_IDLE) |-> cmd_stall)
      else $error("command taken during solve");
   emit_last_idle: assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_EMIT && state_in == ST_IDLE) |-> last_i)
      else $error("solve ended early");
   out_holds: assert property (@(posedge clock) disable iff (reset)
      (out_vld_ff && rsp_stall) |=> (out_vld_ff && $stable(out_ff)))
      else $error("result dropped under stall");

endmodule

@@ rtl/lower_triangular_forward_solve_core.sv @@
// Loads wait in the front queue and are written to the store once the back end,
// which takes commands only while idle, accepts them. Solve element i issues i MAC
// reads, drains the multiplier, then divides serially. Throughput: one load request
// per cycle unless the queue is full; a solve is bounded by the single MAC and divider.
// Reset: synchronous, active high; clears control, size returns to 16.
// Stores are not cleared and read as undefined until written.
module lower_triangular_forward_solve_core (
   input  logic                           clock,
   input  logic                           reset,
   input  logic                           req_valid,
   output logic                           req_stall,
   input  ltfs_pkg::req_type              req_payload,
   output logic                           rsp_valid,
   input  logic                           rsp_stall,
   output ltfs_pkg::rsp_type              rsp_payload,
   input  logic                           csr_write_enable,
   input  logic [ltfs_pkg::SizeW-1:0]     csr_write_data
);
   import ltfs_pkg::*;

   logic [SizeW-1:0] size_ff, size_in;
   logic [SizeW-1:0] dim;
   logic             cmd_valid, cmd_stall;
   cmd_type          cmd_payload;

   assign size_in = csr_write_enable ? csr_write_data : size_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         size_ff <= SizeW'(MaxDim);
      end else begin
         size_ff <= size_in;
      end
   end

   always_comb begin
      if (size_ff == '0) begin
         dim = SizeW'(1);
      end else if (size_ff > SizeW'(MaxDim)) begin
         dim = SizeW'(MaxDim);
      end else begin
         dim = size_ff;
      end
   end

   ltfs_front u_front (
      .clock       (clock),
      .reset       (reset),
      .req_valid   (req_valid),
      .req_stall   (req_stall),
      .req_payload (req_payload),
      .cmd_valid   (cmd_valid),
      .cmd_stall   (cmd_stall),
      .cmd_payload (cmd_payload)
   );

   ltfs_back u_back (
      .clock       (clock),
      .reset       (reset),
      .dim         (dim),
      .cmd_valid   (cmd_valid),
      .cmd_stall   (cmd_stall),
      .cmd_payload (cmd_payload),
      .rsp_valid   (rsp_valid),
      .rsp_stall   (rsp_stall),
      .rsp_payload (rsp_payload)
   );

endmodule
